FILE: hw/rtl/swrm_pkg.sv
// swrm_pkg: shared types and constants for the sliding window rate monitor
// no dependencies; imported by swrm_cell, sliding_window_rate_monitor, swrm_checker and the verif files
`default_nettype none

package swrm_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WINDOW_SIZE          = 2'd0,
        REG_EXPECTED_RATE        = 2'd1,
        REG_RATE_DEVIATION       = 2'd2,
        REG_DEVIATION_MULTIPLIER = 2'd3
    } swrm_reg_idx_t;

    // register widths and reset values
    localparam int WSIZE_W = 5;
    localparam int RATE_W  = 32;
    localparam int MULT_W  = 16;
    localparam int COUNT_W = 32;

    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST          = 5'd10;
    localparam logic [RATE_W-1:0]  EXPECTED_RATE_RST        = 32'd0;
    localparam logic [RATE_W-1:0]  RATE_DEVIATION_RST       = 32'd0;
    localparam logic [MULT_W-1:0]  DEVIATION_MULTIPLIER_RST = 16'd2560;

    // band edges in Q.24 Hz
    localparam int CENTRE_SHIFT = 8;
    localparam int CENTRE_W     = RATE_W + CENTRE_SHIFT;
    localparam int DM_W         = RATE_W + MULT_W;
    localparam int BOUND_W      = DM_W + 1;

    // numerator (w-1) * 1e6 * 2^24
    localparam int USEC_W         = 20;
    localparam int NUM_FRAC_SHIFT = 24;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

    // span is multiplied one 16-bit digit per cycle
    localparam int CHUNK_W = 16;

    // tap selection handed to each cell
    typedef struct packed {
        logic data_sel;
        logic valid_sel;
    } swrm_tap_sel_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sliding_window_rate_monitor.sv
// sliding_window_rate_monitor: arrival rate check over a window of timestamps
// depends on swrm_pkg and swrm_cell
//
// usage
//   input channel (in_valid/in_ready, arrival_time) takes one timestamp per
//   transaction; every transaction gives exactly one result transaction on
//   out_valid/out_ready with checked, out_of_range and the two counters.
//   timestamps enter a chain of WINDOW_MAX cells that shifts on each input
//   transaction; the oldest timestamp of the window is tapped from it.
//   the band products are formed one 16-bit digit of the span per cycle, so
//   the result passes the states prep, mul, cmp and done before it reaches
//   the output register, and a new timestamp is taken only after the last
//   one has left done.
//   in_ready is high only while no timestamp is in work; a finished result
//   sits in the output register, and a stalled receiver holds the block in
//   its last step until out_ready, with the payload held unchanged.
//   configuration writes (cfg_we, cfg_addr, cfg_wdata) are registered; the user
//   must do them while the block is idle, and the block itself does not enforce
//   it; unknown indexes are ignored. reset empties the window, clears both
//   counters and loads the register defaults (window 10, rates 0, multiplier 10.0).
`default_nettype none

module sliding_window_rate_monitor
    import swrm_pkg::*;
#(
    parameter int WINDOW_MAX = 16,
    parameter int TIME_BITS  = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [TIME_BITS-1:0]  arrival_time,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       checked,
    output logic                       out_of_range,
    output logic      [COUNT_W-1:0]    arrival_count,
    output logic      [COUNT_W-1:0]    flagged_count
);

    localparam int WW     = $clog2(WINDOW_MAX + 1);
    localparam int NUM_W  = WW + USEC_W + NUM_FRAC_SHIFT;
    localparam int NCH    = (TIME_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int SPAN_W = NCH * CHUNK_W;
    localparam int PROD_W = BOUND_W + SPAN_W;
    localparam int PP_W   = BOUND_W + CHUNK_W;
    localparam int CNT_W  = $clog2(NCH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    // configuration registers
    logic [WSIZE_W-1:0] window_size_reg;
    logic [RATE_W-1:0]  expected_rate_reg;
    logic [RATE_W-1:0]  rate_deviation_reg;
    logic [MULT_W-1:0]  deviation_multiplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg          <= WINDOW_SIZE_RST;
            expected_rate_reg        <= EXPECTED_RATE_RST;
            rate_deviation_reg       <= RATE_DEVIATION_RST;
            deviation_multiplier_reg <= DEVIATION_MULTIPLIER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WINDOW_SIZE:          window_size_reg <= cfg_wdata[WSIZE_W-1:0];
                REG_EXPECTED_RATE:        expected_rate_reg <= cfg_wdata[RATE_W-1:0];
                REG_RATE_DEVIATION:       rate_deviation_reg <= cfg_wdata[RATE_W-1:0];
                REG_DEVIATION_MULTIPLIER: deviation_multiplier_reg <= cfg_wdata[MULT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // band edges, recomputed every cycle from the registers
    logic [DM_W-1:0]     dm_reg;
    logic [BOUND_W-1:0]  upper_reg;
    logic [BOUND_W-1:0]  lower_reg;
    logic                lower_ok_reg;
    logic [CENTRE_W-1:0] centre;

    assign centre = {expected_rate_reg, {CENTRE_SHIFT{1'b0}}};

    always_ff @(posedge clk)
    begin
        dm_reg       <= DM_W'(rate_deviation_reg) * DM_W'(deviation_multiplier_reg);
        upper_reg    <= BOUND_W'(centre) + BOUND_W'(dm_reg);
        lower_reg    <= BOUND_W'(centre) - BOUND_W'(dm_reg);
        lower_ok_reg <= DM_W'(centre) >= dm_reg;
    end

    // effective window length
    logic [31:0]   ws_clamped;
    logic [WW-1:0] w_eff;

    always_comb
    begin
        ws_clamped = 32'(window_size_reg);
        if (ws_clamped < 32'd2)
        begin
            ws_clamped = 32'd2;
        end
        else if (ws_clamped > 32'(WINDOW_MAX))
        begin
            ws_clamped = 32'(WINDOW_MAX);
        end
        w_eff = ws_clamped[WW-1:0];
    end

    // timestamp chain
    state_t state_reg;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid & in_ready;

    logic [TIME_BITS-1:0] chain_data  [WINDOW_MAX+1];
    logic                 chain_valid [WINDOW_MAX+1];
    logic [TIME_BITS-1:0] tap_data    [WINDOW_MAX];
    logic                 tap_valid   [WINDOW_MAX];

    assign chain_data[0]  = arrival_time;
    assign chain_valid[0] = 1'b1;

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        swrm_tap_sel_t sel;

        assign sel.data_sel  = (32'(w_eff) == 32'(k + 2));
        assign sel.valid_sel = (32'(w_eff) == 32'(k + 1));

        swrm_cell #(
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift     (accept),
            .data_in   (chain_data[k]),
            .valid_in  (chain_valid[k]),
            .tap_sel   (sel),
            .data_out  (chain_data[k+1]),
            .valid_out (chain_valid[k+1]),
            .tap_data  (tap_data[k]),
            .tap_valid (tap_valid[k])
        );
    end

    logic [TIME_BITS-1:0] oldest;
    logic                 window_full;

    always_comb
    begin
        oldest      = '0;
        window_full = 1'b0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            oldest      = oldest | tap_data[i];
            window_full = window_full | tap_valid[i];
        end
    end

    // datapath
    logic [SPAN_W-1:0] span_reg;
    logic [NUM_W-1:0]  num_reg;
    logic              chk_reg;
    logic              le_reg;
    logic [PROD_W-1:0] acc_lo_reg;
    logic [PROD_W-1:0] acc_hi_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              flag_reg;
    logic [PP_W-1:0]   pp_lo;
    logic [PP_W-1:0]   pp_hi;
    logic [PROD_W-1:0] num_ext;

    assign pp_lo   = PP_W'(lower_reg) * PP_W'(span_reg[SPAN_W-1 -: CHUNK_W]);
    assign pp_hi   = PP_W'(upper_reg) * PP_W'(span_reg[SPAN_W-1 -: CHUNK_W]);
    assign num_ext = PROD_W'(num_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            span_reg <= SPAN_W'(arrival_time - oldest);
            le_reg   <= arrival_time <= oldest;
            chk_reg  <= window_full;
            num_reg  <= (NUM_W'(w_eff - WW'(1)) * NUM_W'(USEC_PER_SEC)) << NUM_FRAC_SHIFT;
        end
        if (state_reg == ST_PREP)
        begin
            acc_lo_reg <= '0;
            acc_hi_reg <= '0;
        end
        if (state_reg == ST_MUL)
        begin
            acc_lo_reg <= (acc_lo_reg << CHUNK_W) + PROD_W'(pp_lo);
            acc_hi_reg <= (acc_hi_reg << CHUNK_W) + PROD_W'(pp_hi);
            span_reg   <= span_reg << CHUNK_W;
        end
        if (state_reg == ST_CMP)
        begin
            flag_reg <= chk_reg & (le_reg | (lower_ok_reg & (num_ext < acc_lo_reg))
                                          | (num_ext > acc_hi_reg));
        end
    end

    // control and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid     <= 1'b0;
            checked       <= 1'b0;
            out_of_range  <= 1'b0;
            arrival_count <= '0;
            flagged_count <= '0;
        end
        else
        begin
            if (out_valid && out_ready && state_reg != ST_DONE)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    cnt_reg   <= CNT_W'(NCH - 1);
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid    <= 1'b1;
                        checked      <= chk_reg;
                        out_of_range <= flag_reg;
                        if (arrival_count != '1)
                        begin
                            arrival_count <= arrival_count + COUNT_W'(1);
                        end
                        if (flag_reg && flagged_count != '1)
                        begin
                            flagged_count <= flagged_count + COUNT_W'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/swrm_cell.sv
// swrm_cell: one stage of the timestamp chain, holds one past arrival time
// depends on swrm_pkg (tap selection struct)
`default_nettype none

module swrm_cell
    import swrm_pkg::*;
#(
    parameter int TIME_BITS = 48
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire logic [TIME_BITS-1:0] data_in,
    input  wire logic                 valid_in,
    input  wire swrm_tap_sel_t        tap_sel,
    output logic      [TIME_BITS-1:0] data_out,
    output logic                      valid_out,
    output logic      [TIME_BITS-1:0] tap_data,
    output logic                      tap_valid
);

    logic [TIME_BITS-1:0] data_reg;
    logic                 valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;
    assign tap_data  = tap_sel.data_sel ? data_reg : '0;
    assign tap_valid = tap_sel.valid_sel & valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/swrm_checker.sv
// swrm_checker: port-level assertions for sliding_window_rate_monitor
// depends on swrm_pkg; bound to the top level at the end of this file
`default_nettype none

module swrm_checker
    import swrm_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic               checked,
    input wire logic               out_of_range,
    input wire logic [COUNT_W-1:0] arrival_count,
    input wire logic [COUNT_W-1:0] flagged_count
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(checked)
            && $stable(out_of_range) && $stable(arrival_count) && $stable(flagged_count))
        else $error("result changed while stalled");

    // only a checked arrival can be flagged
    a_flag_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> checked)
        else $error("out_of_range without checked");

    // flagged arrivals never outnumber arrivals
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flagged_count <= arrival_count)
        else $error("flagged_count above arrival_count");

    // one timestamp in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

endmodule

bind sliding_window_rate_monitor swrm_checker u_swrm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .checked       (checked),
    .out_of_range  (out_of_range),
    .arrival_count (arrival_count),
    .flagged_count (flagged_count)
);

`default_nettype wire

FILE: verif/swrm_rate_judge.sv
// swrm_rate_judge: watches the register port and both channels of the rate monitor,
// predicts every result transaction and compares it field by field
// depends on swrm_pkg
`default_nettype none

module swrm_rate_judge
    import swrm_pkg::*;
#(
    parameter int WINDOW_MAX = 16,
    parameter int TIME_BITS  = 48
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [TIME_BITS-1:0]  arrival_time,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic                  checked,
    input  wire logic                  out_of_range,
    input  wire logic [COUNT_W-1:0]    arrival_count,
    input  wire logic [COUNT_W-1:0]    flagged_count,
    output int                         fail_count,
    output int                         outstanding,
    output int                         results_seen,
    output int                         windows_checked,
    output int                         arrivals_flagged
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               checked;
        logic               out_of_range;
        logic [COUNT_W-1:0] arrival_count;
        logic [COUNT_W-1:0] flagged_count;
    } rate_result_t;

    logic [TIME_BITS-1:0] stamp_ring [WINDOW_MAX];
    int unsigned          ring_pos;
    int unsigned          ring_fill;
    logic [COUNT_W-1:0]   seen_total;
    logic [COUNT_W-1:0]   flag_total;

    logic [WSIZE_W-1:0]   window_reg;
    logic [RATE_W-1:0]    rate_reg;
    logic [RATE_W-1:0]    dev_reg;
    logic [MULT_W-1:0]    mult_reg;

    rate_result_t         expected_results [$];
    rate_result_t         want;
    int                   errors = 0;
    int                   n_results = 0;
    int                   n_checked = 0;
    int                   n_flagged = 0;

    function automatic void clear_model();
        ring_pos   = 0;
        ring_fill  = 0;
        seen_total = '0;
        flag_total = '0;
        window_reg = WINDOW_SIZE_RST;
        rate_reg   = EXPECTED_RATE_RST;
        dev_reg    = RATE_DEVIATION_RST;
        mult_reg   = DEVIATION_MULTIPLIER_RST;
        expected_results.delete();
    endfunction

    function automatic rate_result_t judge_arrival(input logic [TIME_BITS-1:0] stamp);
        int unsigned          w;
        int unsigned          old_pos;
        logic [TIME_BITS-1:0] oldest;
        logic [TIME_BITS-1:0] diff;
        logic [127:0]         span;
        logic [127:0]         num;
        logic [127:0]         centre;
        logic [127:0]         spread;
        logic [127:0]         lower;
        logic [127:0]         upper;
        rate_result_t         r;
        w = window_reg;
        if (w < 2)
            w = 2;
        if (w > WINDOW_MAX)
            w = WINDOW_MAX;
        if (seen_total != '1)
            seen_total = seen_total + 1'b1;
        stamp_ring[ring_pos] = stamp;
        r.checked      = 1'b0;
        r.out_of_range = 1'b0;
        if (ring_fill >= w) begin
            old_pos   = (ring_pos + WINDOW_MAX - (w - 1)) % WINDOW_MAX;
            oldest    = stamp_ring[old_pos];
            r.checked = 1'b1;
            if (stamp <= oldest) begin
                r.out_of_range = 1'b1;
            end
            else begin
                diff   = stamp - oldest;
                span   = diff;
                num    = w - 1;
                num    = num * USEC_PER_SEC;
                num    = num << NUM_FRAC_SHIFT;
                centre = rate_reg;
                centre = centre << CENTRE_SHIFT;
                spread = dev_reg;
                spread = spread * mult_reg;
                upper  = centre + spread;
                if (spread <= centre) begin
                    lower = centre - spread;
                    if (num < lower * span)
                        r.out_of_range = 1'b1;
                end
                if (num > upper * span)
                    r.out_of_range = 1'b1;
            end
        end
        if (ring_fill < WINDOW_MAX)
            ring_fill++;
        ring_pos = (ring_pos + 1) % WINDOW_MAX;
        if (r.out_of_range && flag_total != '1)
            flag_total = flag_total + 1'b1;
        r.arrival_count = seen_total;
        r.flagged_count = flag_total;
        return r;
    endfunction

    initial
    begin
        clear_model();
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            clear_model();
        end
        else begin
            if (cfg_we) begin
                case (swrm_reg_idx_t'(cfg_addr))
                    REG_WINDOW_SIZE:          window_reg = cfg_wdata[WSIZE_W-1:0];
                    REG_EXPECTED_RATE:        rate_reg   = cfg_wdata[RATE_W-1:0];
                    REG_RATE_DEVIATION:       dev_reg    = cfg_wdata[RATE_W-1:0];
                    REG_DEVIATION_MULTIPLIER: mult_reg   = cfg_wdata[MULT_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no arrival waiting");
                    errors++;
                end
                else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    n_results++;
                    if (want.checked)
                        n_checked++;
                    if (want.out_of_range)
                        n_flagged++;
                    if (checked !== want.checked) begin
                        $error("checked: expected %0d, actual %0d", want.checked, checked);
                        errors++;
                    end
                    if (out_of_range !== want.out_of_range) begin
                        $error("out_of_range: expected %0d, actual %0d",
                               want.out_of_range, out_of_range);
                        errors++;
                    end
                    if (arrival_count !== want.arrival_count) begin
                        $error("arrival_count: expected %0d, actual %0d",
                               want.arrival_count, arrival_count);
                        errors++;
                    end
                    if (flagged_count !== want.flagged_count) begin
                        $error("flagged_count: expected %0d, actual %0d",
                               want.flagged_count, flagged_count);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(), judge_arrival(arrival_time));
        end
        fail_count       <= errors;
        outstanding      <= expected_results.size();
        results_seen     <= n_results;
        windows_checked  <= n_checked;
        arrivals_flagged <= n_flagged;
    end

endmodule

`default_nettype wire

FILE: verif/tb_sliding_window_rate_monitor.sv
// tb_sliding_window_rate_monitor: drives timestamp streams and register settings into
// the rate monitor and gives the verdict; prediction and comparison sit in swrm_rate_judge
// depends on swrm_pkg, swrm_rate_judge and sliding_window_rate_monitor
`default_nettype none

module tb_sliding_window_rate_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import swrm_pkg::*;

    localparam int TIME_BITS   = 48;
    localparam int WINDOW_MAX  = 16;
    localparam int RESET_CYCLES = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 113;
    localparam int MAX_GAP     = 12;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [TIME_BITS-1:0]  arrival_time = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  checked;
    logic                  out_of_range;
    logic [COUNT_W-1:0]    arrival_count;
    logic [COUNT_W-1:0]    flagged_count;

    int fail_count;
    int outstanding;
    int results_seen;
    int windows_checked;
    int arrivals_flagged;

    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int settings_used = 0;

    logic [TIME_BITS-1:0] stamp;

    sliding_window_rate_monitor #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIME_BITS  (TIME_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .arrival_time  (arrival_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .checked       (checked),
        .out_of_range  (out_of_range),
        .arrival_count (arrival_count),
        .flagged_count (flagged_count)
    );

    swrm_rate_judge #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIME_BITS  (TIME_BITS)
    ) u_rate_judge (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .arrival_time     (arrival_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .checked          (checked),
        .out_of_range     (out_of_range),
        .arrival_count    (arrival_count),
        .flagged_count    (flagged_count),
        .fail_count       (fail_count),
        .outstanding      (outstanding),
        .results_seen     (results_seen),
        .windows_checked  (windows_checked),
        .arrivals_flagged (arrivals_flagged)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic wait_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic send_arrival(input logic [TIME_BITS-1:0] t);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        arrival_time <= t;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_settings(input logic [CFG_DATA_W-1:0] win,
                                  input logic [CFG_DATA_W-1:0] rate,
                                  input logic [CFG_DATA_W-1:0] dev,
                                  input logic [CFG_DATA_W-1:0] mult);
        in_valid <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WINDOW_SIZE;
        cfg_wdata <= win;
        @(posedge clk);
        cfg_addr  <= REG_EXPECTED_RATE;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_addr  <= REG_RATE_DEVIATION;
        cfg_wdata <= dev;
        @(posedge clk);
        cfg_addr  <= REG_DEVIATION_MULTIPLIER;
        cfg_wdata <= mult;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        longint unsigned nominal;
        longint unsigned actual;
        longint unsigned jit;
        longint unsigned rate64;
        longint          step;
        logic [31:0]     rate;
        logic [31:0]     dev;
        logic [31:0]     win;
        logic [31:0]     mult;
        int              shift;
        int              roll;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window of ten, zero-width band at zero
        send_idle_pct = 33;
        recv_idle_pct <= 50;
        stamp = '0;
        for (int i = 0; i < 11; i++) begin
            send_arrival(stamp);
            stamp = stamp + 48'd100000;
        end

        // window below two, band 990..1010 Hz
        write_settings(32'd0, 32'd1000 << 16, 32'd10 << 16, 32'd256);
        stamp = stamp + 48'd1000;
        send_arrival(stamp);
        stamp = stamp + 48'd500;
        send_arrival(stamp);
        stamp = stamp + 48'd2000;
        send_arrival(stamp);
        send_arrival(stamp);
        stamp = stamp - 48'd100;
        send_arrival(stamp);

        // window above max, negative lower edge, widest upper edge
        write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
        send_arrival('1);
        send_arrival('0);

        // window of one, zero band, zero multiplier
        write_settings(32'd1, 32'd0, 32'd0, 32'd0);
        send_arrival(48'd1);
        send_arrival(48'd2);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 33;
                recv_idle_pct <= 50;
            end
            else if (p < 6) begin
                send_idle_pct = 50;
                recv_idle_pct <= 33;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end

            shift   = $urandom_range(0, 19);
            nominal = (64'd1 << shift) + $urandom_range(0, (1 << shift) - 1);
            rate64  = (64'd1000000 << 16) / nominal;
            rate    = (rate64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rate64[31:0];
            dev     = 32'((longint'(rate) / 100) * $urandom_range(0, 15));
            mult    = ($urandom_range(99) < 85) ? $urandom_range(0, 768)
                                                : $urandom_range(0, 65535);
            win     = ($urandom_range(99) < 80) ? $urandom_range(2, 16)
                                                : $urandom_range(0, 31);
            actual  = nominal * $urandom_range(80, 120) / 100;
            if (actual == 0)
                actual = 1;
            jit = actual * $urandom_range(0, 30) / 100;

            write_settings(win | ($urandom() & 32'hFFFF_FFE0), rate, dev,
                           mult | ($urandom() & 32'hFFFF_0000));
            if (p == 4)
                hold_token <= hold_token + 1;

            if (p == 7)
                stamp = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 1000000);
            else
                stamp = {16'($urandom()), 32'($urandom())};

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                roll = $urandom_range(99);
                if (roll < 2) begin
                    stamp = {16'($urandom()), 32'($urandom())};
                end
                else if (roll < 3) begin
                    stamp = stamp;
                end
                else if (roll < 4) begin
                    stamp = stamp - $urandom_range(1, 1000);
                end
                else begin
                    step  = longint'(actual) + longint'($urandom_range(0, 32'(2 * jit)))
                            - longint'(jit);
                    stamp = stamp + 48'(step);
                end
                send_arrival(stamp);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d arrivals under %0d register settings", results_seen,
                 settings_used);
        $display("%0d window checks, %0d arrivals out of band", windows_checked,
                 arrivals_flagged);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
